// ===== hw/rtl/gdc_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date counter.
// No dependencies.
package gdc_pkg;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_FWD  = 2'd1,
      OP_BACK = 2'd2,
      OP_CMP  = 2'd3
   } op_type;

   localparam logic [10:0] FIRST_YEAR     = 11'd1900;
   localparam logic [4:0]  FIRST_YEAR_M25 = 5'd0;      // 1900 mod 25
   localparam logic [4:0]  M25_TOP        = 5'd24;
   localparam logic [3:0]  MONTH_JAN      = 4'd1;
   localparam logic [3:0]  MONTH_DEC      = 4'd12;
   localparam logic [4:0]  DAY_FIRST      = 5'd1;
   localparam logic [4:0]  DAY_DEC_LAST   = 5'd31;

   // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT for any 16-bit y
   localparam logic [16:0] RECIP_25    = 17'd83887;
   localparam int unsigned RECIP_SHIFT = 21;
   localparam int unsigned QUOT_BITS   = 12;

   // leap: y % 4 == 0 and (y % 25 != 0 or y % 16 == 0)
   function automatic logic is_leap(input logic [3:0] y_low, input logic [4:0] y_m25);
      is_leap = (y_low[1:0] == 2'd0) && ((y_m25 != 5'd0) || (y_low == 4'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      case (m) inside
         4'd2:                    month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
         default:                 month_len = 5'd31;
      endcase
   endfunction

endpackage

// ===== hw/rtl/gregorian_date_counter.sv =====
// Gregorian date counter: stored date with set, step forward, step back and compare.
// Depends on gdc_pkg (op codes, constants, leap and month-length helpers).
//
// Usage notes
// - req_ channel: one word per operation (operation, given_day/month/year).
//   rsp_ channel: one word per request, carrying the stored date after the
//   operation plus ok, is_later and is_equal.
// - A word accepted into stage 1 shows on rsp_ once it moves on into the result
//   register; rsp_valid rises as that register loads.
// - Throughput: one word per cycle while rsp_ready is high. Stage 1 registers
//   the request and the given year's quotient by 25 from a 16x17 reciprocal
//   product; stage 2 updates and compares in one pass and loads the result register.
// - The year's residue mod 25 is kept beside the year register and stepped
//   with it, so leap tests on the stored year need no divider.
// - Stalls: while rsp_ready is low the result word holds; one further request
//   can sit in stage 1, after which req_ready drops.
// - Reset (synchronous, active high): date goes to 1 Jan 1900, both stages
//   empty. Payload registers are not reset.
// - YEAR_BITS sets the stored year width; given years are cut to that width,
//   rsp_cur_year shows the low 16 bits.
module gregorian_date_counter #(
   parameter int unsigned YEAR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [4:0]  req_given_day,
   input  logic [3:0]  req_given_month,
   input  logic [15:0] req_given_year,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_cur_day,
   output logic [3:0]  rsp_cur_month,
   output logic [15:0] rsp_cur_year,
   output logic        rsp_ok,
   output logic        rsp_is_later,
   output logic        rsp_is_equal
);
   import gdc_pkg::*;

   typedef logic [YEAR_BITS-1:0] year_type;

   localparam year_type YEAR_MAX = '1;
   localparam year_type YEAR_MIN = year_type'(FIRST_YEAR);

   // ---------------- stage 1: request register ----------------
   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff;
   logic [4:0]           s1_day_ff;
   logic [3:0]           s1_month_ff;
   year_type             s1_year_ff;
   logic [QUOT_BITS-1:0] s1_quot_ff;

   logic                 s1_advance;
   logic                 req_take;
   year_type             req_year_cut;
   logic [15:0]          req_year16;
   logic [32:0]          req_prod;

   // given year cut to the stored width, then quotient by 25 via reciprocal
   assign req_year_cut = year_type'(req_given_year);
   assign req_year16   = 16'(req_year_cut);
   assign req_prod     = 33'(req_year16) * 33'(RECIP_25);

   assign s1_advance = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_op_ff    <= op_type'(req_operation);
         s1_day_ff   <= req_given_day;
         s1_month_ff <= req_given_month;
         s1_year_ff  <= req_year_cut;
         s1_quot_ff  <= req_prod[RECIP_SHIFT +: QUOT_BITS];
      end
   end

   // ---------------- stage 2: date update and compare ----------------
   logic [4:0]  day_ff,   day_in;
   logic [3:0]  month_ff, month_in;
   year_type    year_ff,  year_in;
   logic [4:0]  m25_ff,   m25_in;      // year_ff mod 25

   logic        ok_in, later_in, equal_in;
   logic [15:0] g_year16, g_quot25;
   logic [4:0]  g_m25;
   logic        g_leap, g_valid;
   logic        cur_leap;
   logic [4:0]  cur_len, prev_len;
   logic [3:0]  month_dec;

   // residue of the given year: y - 25*floor(y/25), 25q = 16q + 8q + q
   assign g_year16 = 16'(s1_year_ff);
   assign g_quot25 = (16'(s1_quot_ff) << 4) + (16'(s1_quot_ff) << 3) + 16'(s1_quot_ff);
   assign g_m25    = 5'(g_year16 - g_quot25);
   assign g_leap   = is_leap(s1_year_ff[3:0], g_m25);
   assign g_valid  = (s1_year_ff >= YEAR_MIN)
                  && (s1_month_ff >= MONTH_JAN) && (s1_month_ff <= MONTH_DEC)
                  && (s1_day_ff >= DAY_FIRST)
                  && (s1_day_ff <= month_len(s1_month_ff, g_leap));

   assign cur_leap  = is_leap(year_ff[3:0], m25_ff);
   assign cur_len   = month_len(month_ff, cur_leap);
   assign month_dec = month_ff - 4'd1;
   assign prev_len  = month_len(month_dec, cur_leap);

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      m25_in   = m25_ff;
      ok_in    = 1'b0;
      later_in = 1'b0;
      equal_in = 1'b0;
      unique case (s1_op_ff)
         OP_SET: begin
            if (g_valid) begin
               day_in   = s1_day_ff;
               month_in = s1_month_ff;
               year_in  = s1_year_ff;
               m25_in   = g_m25;
               ok_in    = 1'b1;
            end
         end
         OP_FWD: begin
            if (day_ff < cur_len) begin
               day_in = day_ff + 5'd1;
               ok_in  = 1'b1;
            end else if (month_ff < MONTH_DEC) begin
               day_in   = DAY_FIRST;
               month_in = month_ff + 4'd1;
               ok_in    = 1'b1;
            end else if (year_ff < YEAR_MAX) begin
               day_in   = DAY_FIRST;
               month_in = MONTH_JAN;
               year_in  = year_ff + year_type'(1);
               m25_in   = (m25_ff == M25_TOP) ? 5'd0 : m25_ff + 5'd1;
               ok_in    = 1'b1;
            end
            // last day of the largest year: hold, ok stays low
         end
         OP_BACK: begin
            if (day_ff > DAY_FIRST) begin
               day_in = day_ff - 5'd1;
               ok_in  = 1'b1;
            end else if (month_ff > MONTH_JAN) begin
               month_in = month_dec;
               day_in   = prev_len;
               ok_in    = 1'b1;
            end else if (year_ff > YEAR_MIN) begin
               year_in  = year_ff - year_type'(1);
               month_in = MONTH_DEC;
               day_in   = DAY_DEC_LAST;
               m25_in   = (m25_ff == 5'd0) ? M25_TOP : m25_ff - 5'd1;
               ok_in    = 1'b1;
            end else begin
               // below the first day: pin to 1 Jan of the first year
               day_in   = DAY_FIRST;
               month_in = MONTH_JAN;
               year_in  = YEAR_MIN;
               m25_in   = FIRST_YEAR_M25;
            end
         end
         OP_CMP: begin
            ok_in = 1'b1;
            if (year_ff != s1_year_ff) begin
               later_in = year_ff > s1_year_ff;
            end else if (month_ff != s1_month_ff) begin
               later_in = month_ff > s1_month_ff;
            end else if (day_ff != s1_day_ff) begin
               later_in = day_ff > s1_day_ff;
            end else begin
               equal_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- result register ----------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_day_ff;
   logic [3:0]  rsp_month_ff;
   logic [15:0] rsp_year_ff;
   logic        rsp_ok_ff, rsp_later_ff, rsp_equal_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff       <= DAY_FIRST;
         month_ff     <= MONTH_JAN;
         year_ff      <= YEAR_MIN;
         m25_ff       <= FIRST_YEAR_M25;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
            m25_ff   <= m25_in;
         end
      end
      if (s1_advance) begin
         rsp_day_ff   <= day_in;
         rsp_month_ff <= month_in;
         rsp_year_ff  <= 16'(year_in);
         rsp_ok_ff    <= ok_in;
         rsp_later_ff <= later_in;
         rsp_equal_ff <= equal_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_day   = rsp_day_ff;
   assign rsp_cur_month = rsp_month_ff;
   assign rsp_cur_year  = rsp_year_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_is_later  = rsp_later_ff;
   assign rsp_is_equal  = rsp_equal_ff;

   // ---------------- assertions ----------------
   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      (day_ff >= DAY_FIRST) && (day_ff <= cur_len)
      && (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) && (year_ff >= YEAR_MIN))
      else $error("stored date is not a valid date");

   a_m25_range: assert property (@(posedge clock) disable iff (reset)
      m25_ff <= M25_TOP)
      else $error("year residue mod 25 out of range");

   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> !(rsp_is_later && rsp_is_equal))
      else $error("compare flags both set");

   a_date_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(day_ff) && $stable(month_ff) && $stable(year_ff))
      else $error("stored date changed without an operation");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && !rsp_ready) |=> s1_valid_ff && rsp_valid)
      else $error("word lost while result stalled");

endmodule
